>>> src/servo_pd_steering_defines.svh
// Assertion macros shared by the steering controller modules.
`ifndef SERVO_PD_STEERING_DEFINES_SVH
`define SERVO_PD_STEERING_DEFINES_SVH
`ifndef SYNTHESIS
`define SPD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("servo_pd_steering: check failed");
`define SPD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("servo_pd_steering: check failed");
`else
`define SPD_ASSERT(lbl, clk, rst, prop)
`define SPD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> src/spd_pkg.sv
// Shared types, constants and fixed-point helpers of the steering controller.
package spd_pkg;

   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int GAIN_KNEE_DEFAULT        = 10;
   localparam int STOP_HOLD_FRAMES_DEFAULT = 150;

   // run state codes carried in the kind field
   localparam logic [1:0] KIND_RUN  = 2'd0;
   localparam logic [1:0] KIND_STOP = 2'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CENTER_DUTY,
      REG_LEFT_LIMIT,
      REG_RIGHT_LIMIT,
      REG_QUAD_GAIN,
      REG_BASE_GAIN,
      REG_D_GAIN,
      REG_D_WEIGHT,
      REG_RIGHT_SCALE
   } reg_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_WEIGHT,
      ST_GAIN,
      ST_PROP,
      ST_LIMIT,
      ST_SCALE,
      ST_NORM,
      ST_OFFSET,
      ST_RESULT
   } state_type;

   // one strobe per datapath step
   typedef struct packed {
      logic load;
      logic square;
      logic weight;
      logic gain;
      logic prop;
      logic limit;
      logic scale;
      logic norm;
      logic offset;
      logic result;
   } cmd_type;

   // register file as seen by the datapath; Q16 factors are formed at write time
   typedef struct packed {
      logic [15:0] center_duty;
      logic [15:0] left_limit;
      logic [15:0] right_limit;
      logic [18:0] quad_q;       // quad_gain / 10000, Q16
      logic [21:0] base_q;       // base_gain / 10, Q16
      logic [11:0] d_gain;
      logic [16:0] weight_q;     // d_weight / 10, Q16
      logic [17:0] weight_rest;  // 1 - weight_q, two's complement
      logic [17:0] scale_q;      // right_scale / 100, Q16
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      center_duty: 16'd3550,
      left_limit:  16'd2800,
      right_limit: 16'd4350,
      quad_q:      19'd0,
      base_q:      22'd0,
      d_gain:      12'd0,
      weight_q:    17'd65536,
      weight_rest: 18'd0,
      scale_q:     18'd65536
   };

   // floor(q * 65536 / 10000): reciprocal estimate, then one correction step
   function automatic logic [18:0] quad_q16(input logic [15:0] q);
      logic [34:0] prod;
      logic [18:0] est;
      logic [28:0] num;
      logic [28:0] back;
      logic [28:0] rem;
      prod = {19'd0, q} * 35'd429496;
      est  = prod[34:16];
      num  = {1'b0, q, 12'd0};
      back = {10'd0, est} * 29'd625;
      rem  = num - back;
      quad_q16 = (rem >= 29'd625) ? est + 19'd1 : est;
   endfunction

   // floor(b * 65536 / 10)
   function automatic logic [21:0] tenth_q16(input logic [8:0] b);
      logic [31:0] prod;
      logic [21:0] est;
      logic [23:0] num;
      logic [23:0] back;
      logic [23:0] rem;
      prod = {23'd0, b} * 32'd6710886;
      est  = prod[31:10];
      num  = {b, 15'd0};
      back = {2'd0, est} * 24'd5;
      rem  = num - back;
      tenth_q16 = (rem >= 24'd5) ? est + 22'd1 : est;
   endfunction

   // floor(r * 65536 / 100)
   function automatic logic [17:0] pct_q16(input logic [7:0] r);
      logic [27:0] prod;
      logic [17:0] est;
      logic [21:0] num;
      logic [21:0] back;
      logic [21:0] rem;
      prod = {20'd0, r} * 28'd671088;
      est  = prod[27:10];
      num  = {r, 14'd0};
      back = {4'd0, est} * 22'd25;
      rem  = num - back;
      pct_q16 = (rem >= 22'd25) ? est + 18'd1 : est;
   endfunction

endpackage

>>> src/servo_pd_steering.sv
// Top level of the PD steering servo controller with gain scheduling.
// One steering error per transaction goes in, one duty transaction comes out.
// The block works on one item at a time: it is accepted in the idle state,
// runs through nine registered datapath steps (square, weight products, gain
// schedule and D clamp, P product, travel clamp, right-turn partial products,
// normalize, center offset, final limit), and the result is registered in the
// final step. The sequencer returns to idle as the result is registered and only
// then takes the next item; a result still waiting on rsp_tready holds the
// sequencer in its last step. The error history (last two errors) advances on
// every item, whatever the run state. Configuration writes are taken every cycle
// and act from the next cycle; the Q16 gain and scale factors are formed when
// the register is written.
module servo_pd_steering #(
   parameter int GAIN_KNEE        = spd_pkg::GAIN_KNEE_DEFAULT,
   parameter int STOP_HOLD_FRAMES = spd_pkg::STOP_HOLD_FRAMES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [7:0] error, [8] stop_marked, [24:9] frames_since_stop, rest zero
   input  logic [spd_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] kind
   input  logic [spd_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [15:0] duty, [16] drive, rest zero
   output logic [spd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [spd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spd_pkg::CSR_DATA_W-1:0] csr_data
);
   import spd_pkg::*;

   cmd_type     cmd;
   cfg_type     cfg;
   logic [15:0] duty;
   logic        drive;

   spd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   spd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   spd_dp #(
      .GAIN_KNEE        (GAIN_KNEE),
      .STOP_HOLD_FRAMES (STOP_HOLD_FRAMES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .in_error  (req_tdata[7:0]),
      .in_kind   (req_tuser[1:0]),
      .in_marked (req_tdata[8]),
      .in_since  (req_tdata[24:9]),
      .out_duty  (duty),
      .out_drive (drive)
   );

   assign rsp_tdata = {7'd0, drive, duty};

endmodule

>>> src/spd_csr.sv
// Configuration register file with write-time conversion to Q16 factors.
module spd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [spd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spd_pkg::CSR_DATA_W-1:0] csr_data,
   output spd_pkg::cfg_type              cfg
);
   import spd_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic [21:0] tenth_full;
   logic [21:0] weight_full;
   logic [16:0] weight_q;

   assign csr_ready   = 1'b1;
   assign tenth_full  = tenth_q16(csr_data[8:0]);
   assign weight_full = tenth_q16({5'd0, csr_data[3:0]});
   assign weight_q    = weight_full[16:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (reg_idx_type'(csr_index))
            REG_CENTER_DUTY: cfg_in.center_duty = csr_data;
            REG_LEFT_LIMIT:  cfg_in.left_limit  = csr_data;
            REG_RIGHT_LIMIT: cfg_in.right_limit = csr_data;
            REG_QUAD_GAIN:   cfg_in.quad_q      = quad_q16(csr_data);
            REG_BASE_GAIN:   cfg_in.base_q      = tenth_full;
            REG_D_GAIN:      cfg_in.d_gain      = csr_data[11:0];
            REG_D_WEIGHT: begin
               cfg_in.weight_q    = weight_q;
               // goes negative for weights above ten tenths
               cfg_in.weight_rest = 18'd65536 - {1'b0, weight_q};
            end
            REG_RIGHT_SCALE: cfg_in.scale_q     = pct_q16(csr_data[7:0]);
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/spd_dp.sv
// Datapath: error history, gain schedule, P and D terms, scaling and duty clamp.
`include "servo_pd_steering_defines.svh"
module spd_dp #(
   parameter int GAIN_KNEE        = spd_pkg::GAIN_KNEE_DEFAULT,
   parameter int STOP_HOLD_FRAMES = spd_pkg::STOP_HOLD_FRAMES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  spd_pkg::cmd_type cmd,
   input  spd_pkg::cfg_type cfg,
   input  logic [7:0]       in_error,
   input  logic [1:0]       in_kind,
   input  logic             in_marked,
   input  logic [15:0]      in_since,
   output logic [15:0]      out_duty,
   output logic             out_drive
);
   import spd_pkg::*;

   localparam logic [21:0]        GAIN_CAP         = 22'd3276800;    // 50.0 in Q16
   localparam logic signed [36:0] UD_CAP           = 37'sd45875200;  // 700.0 in Q16
   localparam logic signed [36:0] UD_FLOOR         = -37'sd45875200;

   // history and captured item
   logic signed [7:0]  last_ff, last_in, prev_ff, prev_in;
   logic signed [7:0]  e_ff, e_in;
   logic [1:0]         kind_ff, kind_in;
   logic               marked_ff, marked_in;
   logic [15:0]        since_ff, since_in;
   logic signed [8:0]  dn_ff, dn_in, dl_ff, dl_in;
   // step registers
   logic [14:0]        e2_ff, e2_in;
   logic               big_ff, big_in;
   logic signed [21:0] gdn_ff, gdn_in, gdl_ff, gdl_in;
   logic [33:0]        pm_ff, pm_in;
   logic signed [39:0] udn_ff, udn_in, udl_ff, udl_in;
   logic [21:0]        p_ff, p_in;
   logic signed [26:0] ud_ff, ud_in;
   logic signed [30:0] upm_ff, upm_in;
   logic signed [33:0] s_ff, s_in;
   logic signed [36:0] ph_ff, ph_in;
   logic [33:0]        pl_ff, pl_in;
   logic signed [35:0] s2_ff, s2_in;
   logic signed [36:0] t_ff, t_in;
   logic [15:0]        duty_ff, duty_in;
   logic               drive_ff, drive_in;

   // combinational intermediates
   logic signed [15:0] e_sq;
   logic [7:0]         ae;
   logic [34:0]        psum, praw;
   logic signed [39:0] udn_rnd, udl_rnd;
   logic signed [35:0] tn, tl;
   logic signed [36:0] uds;
   logic signed [16:0] hi_diff, lo_diff;
   logic signed [32:0] hi_q, lo_q, u1, u2;
   logic signed [17:0] s_hi;
   logic signed [52:0] ph_sh;
   logic signed [53:0] prod_q;
   logic signed [37:0] q_sh, q_tr;
   logic               q_corr;
   logic signed [20:0] d_sh, d_tr, d_lo;
   logic               d_corr;
   logic               live;

   always_comb begin
      // hold by default
      last_in   = last_ff;
      prev_in   = prev_ff;
      e_in      = e_ff;
      kind_in   = kind_ff;
      marked_in = marked_ff;
      since_in  = since_ff;
      dn_in     = dn_ff;
      dl_in     = dl_ff;
      e2_in     = e2_ff;
      big_in    = big_ff;
      gdn_in    = gdn_ff;
      gdl_in    = gdl_ff;
      pm_in     = pm_ff;
      udn_in    = udn_ff;
      udl_in    = udl_ff;
      p_in      = p_ff;
      ud_in     = ud_ff;
      upm_in    = upm_ff;
      s_in      = s_ff;
      ph_in     = ph_ff;
      pl_in     = pl_ff;
      s2_in     = s2_ff;
      t_in      = t_ff;
      duty_in   = duty_ff;
      drive_in  = drive_ff;

      // square / D-gain products
      e_sq = e_ff * e_ff;
      ae   = e_ff[7] ? 8'($unsigned(8'd0 - e_ff)) : 8'($unsigned(e_ff));

      // gain schedule and D blend
      psum    = {1'b0, pm_ff} + {13'd0, cfg.base_q};
      praw    = big_ff ? psum : {13'd0, cfg.base_q};
      udn_rnd = udn_ff + (udn_ff[39] ? 40'sd15 : 40'sd0);
      udl_rnd = udl_ff + (udl_ff[39] ? 40'sd15 : 40'sd0);
      tn      = udn_rnd[39:4];
      tl      = udl_rnd[39:4];
      uds     = tn + tl;

      // P clamp to servo travel, upper bound first
      hi_diff = $signed({1'b0, cfg.right_limit}) - $signed({1'b0, cfg.center_duty});
      lo_diff = $signed({1'b0, cfg.left_limit}) - $signed({1'b0, cfg.center_duty});
      hi_q    = {hi_diff, 16'h0000};
      lo_q    = {lo_diff, 16'h0000};
      u1      = (upm_ff > hi_q) ? hi_q : upm_ff;
      u2      = (u1 < lo_q) ? lo_q : u1;

      // right-turn scaling split into high and low partial products
      s_hi   = s_ff[33:16];
      ph_sh  = {ph_ff, 16'h0000};
      prod_q = ph_sh + $signed({19'd0, pl_ff});
      q_sh   = prod_q[53:16];
      q_corr = prod_q[53] && (prod_q[15:0] != 16'h0000);
      q_tr   = q_sh + $signed({37'd0, q_corr});

      // back to duty units, truncating toward zero, then limit
      d_sh   = t_ff[36:16];
      d_corr = t_ff[36] && (t_ff[15:0] != 16'h0000);
      d_tr   = d_sh + $signed({20'd0, d_corr});
      d_lo   = (d_tr < $signed({5'd0, cfg.left_limit})) ? $signed({5'd0, cfg.left_limit})
                                                        : d_tr;
      live   = (kind_ff == KIND_RUN) ||
               ((kind_ff == KIND_STOP) && marked_ff &&
                (since_ff < 16'(STOP_HOLD_FRAMES)));

      if (cmd.load) begin
         e_in      = in_error;
         kind_in   = in_kind;
         marked_in = in_marked;
         since_in  = in_since;
         dn_in     = {in_error[7], in_error} - {last_ff[7], last_ff};
         dl_in     = {last_ff[7], last_ff} - {prev_ff[7], prev_ff};
         prev_in   = last_ff;
         last_in   = in_error;
      end
      if (cmd.square) begin
         e2_in  = e_sq[14:0];
         big_in = ae > 8'(GAIN_KNEE);
         gdn_in = $signed({1'b0, cfg.d_gain}) * dn_ff;
         gdl_in = $signed({1'b0, cfg.d_gain}) * dl_ff;
      end
      if (cmd.weight) begin
         pm_in  = e2_ff * cfg.quad_q;
         udn_in = gdn_ff * $signed({1'b0, cfg.weight_q});
         udl_in = gdl_ff * $signed(cfg.weight_rest);
      end
      if (cmd.gain) begin
         p_in = (praw > {13'd0, GAIN_CAP}) ? GAIN_CAP : praw[21:0];
         if (uds > UD_CAP) begin
            ud_in = UD_CAP[26:0];
         end else if (uds < UD_FLOOR) begin
            ud_in = UD_FLOOR[26:0];
         end else begin
            ud_in = uds[26:0];
         end
      end
      if (cmd.prop) begin
         upm_in = $signed({1'b0, p_ff}) * e_ff;
      end
      if (cmd.limit) begin
         s_in = u2 + ud_ff;
      end
      if (cmd.scale) begin
         ph_in = s_hi * $signed({1'b0, cfg.scale_q});
         pl_in = s_ff[15:0] * cfg.scale_q;
      end
      if (cmd.norm) begin
         if (e_ff[7]) begin
            s2_in = 36'(s_ff);
         end else begin
            s2_in = q_tr[35:0];
         end
      end
      if (cmd.offset) begin
         t_in = $signed({5'd0, cfg.center_duty, 16'h0000}) + s2_ff;
      end
      if (cmd.result) begin
         if (live) begin
            duty_in  = (d_lo > $signed({5'd0, cfg.right_limit})) ? cfg.right_limit
                                                                 : d_lo[15:0];
            drive_in = 1'b1;
         end else if (kind_ff == KIND_STOP) begin
            duty_in  = cfg.center_duty;
            drive_in = 1'b1;
         end else begin
            duty_in  = 16'h0000;
            drive_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         prev_ff <= '0;
      end else begin
         last_ff <= last_in;
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff      <= e_in;
      kind_ff   <= kind_in;
      marked_ff <= marked_in;
      since_ff  <= since_in;
      dn_ff     <= dn_in;
      dl_ff     <= dl_in;
      e2_ff     <= e2_in;
      big_ff    <= big_in;
      gdn_ff    <= gdn_in;
      gdl_ff    <= gdl_in;
      pm_ff     <= pm_in;
      udn_ff    <= udn_in;
      udl_ff    <= udl_in;
      p_ff      <= p_in;
      ud_ff     <= ud_in;
      upm_ff    <= upm_in;
      s_ff      <= s_in;
      ph_ff     <= ph_in;
      pl_ff     <= pl_in;
      s2_ff     <= s2_in;
      t_ff      <= t_in;
      duty_ff   <= duty_in;
      drive_ff  <= drive_in;
   end

   assign out_duty  = duty_ff;
   assign out_drive = drive_ff;

   `SPD_ASSERT(a_history_shift, clock, reset, cmd.load |=> (prev_ff == $past(last_ff)))
   `SPD_ASSERT(a_undriven_zero, clock, reset, cmd.result |=> (drive_ff || duty_ff == 16'h0000))

endmodule

>>> src/spd_ctrl.sv
// Step sequencer and output handshake of the steering controller.
`include "servo_pd_steering_defines.svh"
module spd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output spd_pkg::cmd_type cmd
);
   import spd_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      slot_free;

   assign slot_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_tready    = 1'b0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_WEIGHT;
         end
         ST_WEIGHT: begin
            cmd.weight = 1'b1;
            state_in   = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.gain = 1'b1;
            state_in = ST_PROP;
         end
         ST_PROP: begin
            cmd.prop = 1'b1;
            state_in = ST_LIMIT;
         end
         ST_LIMIT: begin
            cmd.limit = 1'b1;
            state_in  = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_NORM;
         end
         ST_NORM: begin
            cmd.norm = 1'b1;
            state_in = ST_OFFSET;
         end
         ST_OFFSET: begin
            cmd.offset = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            // wait here while the previous result is still unclaimed
            if (slot_free) begin
               cmd.result    = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

   `SPD_ASSERT(a_accept_starts, clock, reset, (req_tvalid && req_tready) |=> (state_ff == ST_SQUARE))
   `SPD_ASSERT(a_result_posts, clock, reset, (state_ff == ST_RESULT && slot_free) |=> (rsp_tvalid_ff && state_ff == ST_IDLE))
   `SPD_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (state_ff == ST_IDLE && !rsp_tvalid_ff))

endmodule
